/* design/mfi_pkg.sv */
package mfi_pkg;

   localparam int MAX_LAYERS  = 4;
   localparam int MAX_INPUTS  = 1024;
   localparam int MAX_NEURONS = 64;
   localparam int FRAC_BITS   = 12;

   localparam int COL_W   = $clog2(MAX_INPUTS);
   localparam int ROW_W   = $clog2(MAX_NEURONS);
   localparam int CNT_W   = ROW_W + 1;
   localparam int LAY_W   = 3;
   localparam int DATA_W  = 16;
   localparam int SUM_W   = 32;
   localparam int ACT_W   = FRAC_BITS + 1;
   localparam int PROD_W  = 2 * DATA_W + 1;
   localparam int TERM_W  = PROD_W - FRAC_BITS;
   localparam int NUM_W   = SUM_W + 2 * FRAC_BITS - 10;
   localparam int BIAS_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS;
   localparam int DEEP_DEPTH = (MAX_LAYERS - 2) * MAX_NEURONS * MAX_NEURONS;
   localparam int FIRST_DEPTH = MAX_NEURONS * MAX_INPUTS;
   localparam int ACT_DEPTH  = 2 * MAX_NEURONS;

   typedef enum logic [1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_SPARE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_LAYER_COUNT = 3'd0,
      CSR_INPUT_SIZE  = 3'd1,
      CSR_SIZE_ONE    = 3'd2,
      CSR_SIZE_TWO    = 3'd3,
      CSR_SIZE_THREE  = 3'd4
   } csr_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_E_RD,
      ST_E_MUL,
      ST_E_ACC,
      ST_F_RD,
      ST_F_ADD,
      ST_D_BIAS,
      ST_D_BLD,
      ST_D_RD,
      ST_D_MUL,
      ST_D_ACC,
      ST_SQ,
      ST_DIV,
      ST_O_RD,
      ST_O_LD,
      ST_O_WAIT
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [SUM_W-1:0] z;
   } sq_req_type;

   typedef struct packed {
      logic done;
      logic [ACT_W-1:0] act;
   } sq_rsp_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = $signed({a[SUM_W-1], a}) + $signed({b[SUM_W-1], b});
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat_add = s[SUM_W-1:0];
      end
   endfunction

   function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v);
      if (v == '0) begin
         clamp_size = CNT_W'(1);
      end else if (v > CNT_W'(MAX_NEURONS)) begin
         clamp_size = CNT_W'(MAX_NEURONS);
      end else begin
         clamp_size = v;
      end
   endfunction

endpackage

/* design/mfi_mac.sv */
module mfi_mac (
   input  logic clock,
   input  logic load,
   input  logic signed [mfi_pkg::DATA_W-1:0] a,
   input  logic signed [mfi_pkg::DATA_W:0] b,
   output logic signed [mfi_pkg::TERM_W-1:0] term
);
   import mfi_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // dropping the fraction bits rounds toward minus infinity
   assign term = prod_ff[PROD_W-1:FRAC_BITS];

endmodule

/* design/mfi_squash.sv */
module mfi_squash (
   input  logic clock,
   input  logic reset,
   input  mfi_pkg::sq_req_type sq_req,
   output mfi_pkg::sq_rsp_type sq_rsp
);
   import mfi_pkg::*;

   localparam int DIV_W = NUM_W;
   localparam logic [3:0] LAST_BIT = 4'(ACT_W - 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [ACT_W-1:0] q_ff, q_in;
   logic [3:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [SUM_W-1:0] absz;
   logic [SUM_W+1:0] base, den, num;
   logic ge;

   always_comb begin
      absz = sq_req.z[SUM_W-1] ? SUM_W'(-sq_req.z) : SUM_W'(sq_req.z);
      base = (SUM_W+2)'(1 << FRAC_BITS) + (SUM_W+2)'(absz);
      den  = {base[SUM_W:0], 1'b0};
      num  = sq_req.z[SUM_W-1] ? (SUM_W+2)'(1 << FRAC_BITS)
                               : (SUM_W+2)'(1 << FRAC_BITS) + {1'b0, absz, 1'b0};
      ge   = rem_ff >= dsr_ff;
   end

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (sq_req.start) begin
         // numerator already carries half the divisor for rounding
         rem_in  = (DIV_W'(num) << FRAC_BITS) + DIV_W'(base);
         dsr_in  = DIV_W'(den) << FRAC_BITS;
         q_in    = '0;
         cnt_in  = LAST_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dsr_ff : rem_ff;
         dsr_in = dsr_ff >> 1;
         q_in   = {q_ff[ACT_W-2:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.act  = q_ff;

endmodule

/* design/mlp_feedforward_inference_unit.sv */
// weight and bias writes are written to memory as the request is accepted
// a sample element passes through the shared multiplier once per first-layer neuron
// after the last element each first-layer neuron adds its bias and is squashed, each deeper
// neuron adds its bias, accumulates its inputs and is squashed, and each result beat holds through output stall
// one item at a time; the squash divider settles one quotient bit a cycle
// synchronous reset clears control and partial-sum valid bits and sets the configuration registers to defaults
module mlp_feedforward_inference_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // row_index, col_index, value
   input  logic [3:0]  req_tuser,  // opcode, layer_sel
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // neuron_index, activation_out, best_class, zero pad
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfi_pkg::*;

   // configuration
   logic [2:0]       layer_count_ff;
   logic [COL_W:0]   input_size_ff;
   logic [CNT_W-1:0] size_one_ff, size_two_ff, size_three_ff;
   logic             csr_we;
   csr_type          csr_idx;

   assign csr_pready = 1'b1;
   assign csr_we  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= 3'd3;
         input_size_ff  <= (COL_W+1)'(784);
         size_one_ff    <= CNT_W'(30);
         size_two_ff    <= CNT_W'(10);
         size_three_ff  <= CNT_W'(10);
      end else if (csr_we) begin
         case (csr_idx)
            CSR_LAYER_COUNT: layer_count_ff <= csr_pwdata[2:0];
            CSR_INPUT_SIZE:  input_size_ff  <= csr_pwdata[COL_W:0];
            CSR_SIZE_ONE:    size_one_ff    <= csr_pwdata[CNT_W-1:0];
            CSR_SIZE_TWO:    size_two_ff    <= csr_pwdata[CNT_W-1:0];
            CSR_SIZE_THREE:  size_three_ff  <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_LAYER_COUNT: csr_prdata = 32'(layer_count_ff);
         CSR_INPUT_SIZE:  csr_prdata = 32'(input_size_ff);
         CSR_SIZE_ONE:    csr_prdata = 32'(size_one_ff);
         CSR_SIZE_TWO:    csr_prdata = 32'(size_two_ff);
         CSR_SIZE_THREE:  csr_prdata = 32'(size_three_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // request fields
   opcode_type              req_op;
   logic [1:0]              req_layer;
   logic [ROW_W-1:0]        req_row;
   logic [COL_W-1:0]        req_col;
   logic signed [DATA_W-1:0] req_value;
   logic                    req_fire;

   assign req_op    = opcode_type'(req_tuser[1:0]);
   assign req_layer = req_tuser[3:2];
   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[15:6];
   assign req_value = req_tdata[31:16];
   assign req_fire  = req_tvalid & req_tready;

   // sequencer state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] r_ff, c_ff;
   logic [1:0]       l_ff;
   logic [COL_W-1:0] col_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic             last_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic [ROW_W-1:0] best_ff;
   logic [ACT_W-1:0] bestv_ff;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_data_ff;
   logic             rsp_last_ff;

   // derived sizes
   logic [LAY_W-1:0] nlay;
   logic [CNT_W-1:0] s_one, out_size, in_size, r_next, c_next;
   logic             final_layer, elem_ok;

   always_comb begin
      nlay = layer_count_ff;
      if (nlay < 3'd2) nlay = 3'd2;
      if (nlay > LAY_W'(MAX_LAYERS)) nlay = LAY_W'(MAX_LAYERS);
      s_one = clamp_size(size_one_ff);
      case (l_ff)
         2'd0:    out_size = s_one;
         2'd1:    out_size = clamp_size(size_two_ff);
         default: out_size = clamp_size(size_three_ff);
      endcase
      case (l_ff)
         2'd2:    in_size = clamp_size(size_two_ff);
         default: in_size = s_one;
      endcase
      r_next      = r_ff + CNT_W'(1);
      c_next      = c_ff + CNT_W'(1);
      final_layer = ({1'b0, l_ff} + 3'd2) == nlay;
      elem_ok     = {1'b0, req_col} < input_size_ff;
   end

   // memories
   logic signed [DATA_W-1:0] wfirst_mem [0:FIRST_DEPTH-1];
   logic signed [DATA_W-1:0] wdeep_mem  [0:DEEP_DEPTH-1];
   logic signed [DATA_W-1:0] bias_mem   [0:BIAS_DEPTH-1];
   logic signed [SUM_W-1:0]  sum_mem    [0:MAX_NEURONS-1];
   logic [ACT_W-1:0]         act_mem    [0:ACT_DEPTH-1];
   logic [MAX_NEURONS-1:0]   sum_valid_ff;

   logic signed [DATA_W-1:0] wfirst_rd_ff, wdeep_rd_ff, bias_rd_ff;
   logic signed [SUM_W-1:0]  sum_rd_ff;
   logic [ACT_W-1:0]         act_rd_ff;
   logic [ROW_W:0]           act_raddr;

   logic wf_we, wd_we, b_we;
   assign wf_we = req_fire && req_op == OP_WEIGHT && req_layer == 2'd0;
   assign wd_we = req_fire && req_op == OP_WEIGHT && (req_layer == 2'd1 || req_layer == 2'd2)
                  && req_col[COL_W-1:ROW_W] == '0;
   assign b_we  = req_fire && req_op == OP_BIAS && req_layer != 2'd3;

   always_ff @(posedge clock) begin
      if (wf_we) wfirst_mem[{req_row, req_col}] <= req_value;
      wfirst_rd_ff <= wfirst_mem[{r_ff[ROW_W-1:0], col_ff}];
   end

   always_ff @(posedge clock) begin
      if (wd_we) wdeep_mem[{req_layer[1], req_row, req_col[ROW_W-1:0]}] <= req_value;
      wdeep_rd_ff <= wdeep_mem[{l_ff[1], r_ff[ROW_W-1:0], c_ff[ROW_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (b_we) bias_mem[{req_layer, req_row}] <= req_value;
      bias_rd_ff <= bias_mem[{l_ff, r_ff[ROW_W-1:0]}];
   end

   // shared units
   logic                     mac_load;
   logic signed [DATA_W:0]   mac_b;
   logic signed [TERM_W-1:0] mac_term;
   logic signed [SUM_W-1:0]  term_ext, sum_eff, sum_new;
   sq_req_type               sq_req;
   sq_rsp_type               sq_rsp;

   assign mac_b = (state_ff == ST_E_MUL) ? {val_ff[DATA_W-1], val_ff}
                                         : $signed({{(DATA_W+1-ACT_W){1'b0}}, act_rd_ff});

   mfi_mac u_mac (
      .clock (clock),
      .load  (mac_load),
      .a     ((state_ff == ST_E_MUL) ? wfirst_rd_ff : wdeep_rd_ff),
      .b     (mac_b),
      .term  (mac_term)
   );

   mfi_squash u_squash (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   assign term_ext = {{(SUM_W-TERM_W){mac_term[TERM_W-1]}}, mac_term};
   assign sum_eff  = sum_valid_ff[r_ff[ROW_W-1:0]] ? sum_rd_ff : '0;
   assign sum_new  = sat_add(sum_eff, term_ext);

   // write and read controls
   logic sum_we, sum_clear, act_we;

   always_comb begin
      mac_load     = 1'b0;
      sq_req.start = 1'b0;
      sq_req.z     = acc_ff;
      sum_we       = 1'b0;
      sum_clear    = 1'b0;
      act_we       = 1'b0;
      act_raddr    = {~l_ff[0], c_ff[ROW_W-1:0]};
      case (state_ff)
         ST_E_MUL: mac_load = 1'b1;
         ST_D_MUL: mac_load = 1'b1;
         ST_E_ACC: sum_we = 1'b1;
         ST_SQ:    sq_req.start = 1'b1;
         ST_DIV: begin
            act_we = sq_rsp.done;
            // first layer finished: every partial sum starts afresh
            sum_clear = sq_rsp.done && l_ff == 2'd0 && r_next == out_size;
         end
         ST_O_RD:  act_raddr = {l_ff[0], r_ff[ROW_W-1:0]};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[r_ff[ROW_W-1:0]] <= sum_new;
      sum_rd_ff <= sum_mem[r_ff[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (act_we) act_mem[{l_ff[0], r_ff[ROW_W-1:0]}] <= sq_rsp.act;
      act_rd_ff <= act_mem[act_raddr];
   end

   // partial sums read as zero until written after reset or the last sample
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= '0;
      end else if (sum_we) begin
         sum_valid_ff[r_ff[ROW_W-1:0]] <= 1'b1;
      end else if (sum_clear) begin
         sum_valid_ff <= '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_SAMPLE) begin
               if (elem_ok) state_in = ST_E_RD;
               else if (req_tlast) state_in = ST_F_RD;
            end
         end
         ST_E_RD:   state_in = ST_E_MUL;
         ST_E_MUL:  state_in = ST_E_ACC;
         ST_E_ACC: begin
            if (r_next != s_one) state_in = ST_E_RD;
            else if (last_ff) state_in = ST_F_RD;
            else state_in = ST_IDLE;
         end
         ST_F_RD:   state_in = ST_F_ADD;
         ST_F_ADD:  state_in = ST_SQ;
         ST_D_BIAS: state_in = ST_D_BLD;
         ST_D_BLD:  state_in = ST_D_RD;
         ST_D_RD:   state_in = ST_D_MUL;
         ST_D_MUL:  state_in = ST_D_ACC;
         ST_D_ACC:  state_in = (c_next == in_size) ? ST_SQ : ST_D_RD;
         ST_SQ:     state_in = ST_DIV;
         ST_DIV: begin
            if (sq_rsp.done) begin
               if (r_next != out_size) state_in = (l_ff == 2'd0) ? ST_F_RD : ST_D_BIAS;
               else if (final_layer) state_in = ST_O_RD;
               else state_in = ST_D_BIAS;
            end
         end
         ST_O_RD:   state_in = ST_O_LD;
         ST_O_LD:   state_in = ST_O_WAIT;
         ST_O_WAIT: begin
            if (rsp_tready) state_in = rsp_last_ff ? ST_IDLE : ST_O_RD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         r_ff         <= '0;
         c_ff         <= '0;
         l_ff         <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               r_ff <= '0;
               c_ff <= '0;
               l_ff <= '0;
            end
            ST_E_ACC: r_ff <= (r_next == s_one) ? '0 : r_next;
            ST_D_BLD: c_ff <= '0;
            ST_D_ACC: c_ff <= c_next;
            ST_DIV: begin
               if (sq_rsp.done) begin
                  if (r_next != out_size) begin
                     r_ff <= r_next;
                  end else if (!final_layer) begin
                     r_ff <= '0;
                     l_ff <= l_ff + 2'd1;
                  end else begin
                     r_ff <= '0;
                  end
               end
            end
            ST_O_LD: rsp_valid_ff <= 1'b1;
            ST_O_WAIT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  r_ff <= r_next;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            col_ff  <= req_col;
            val_ff  <= req_value;
            last_ff <= req_tlast;
         end
         ST_F_ADD: acc_ff <= sat_add(sum_eff, SUM_W'(bias_rd_ff));
         ST_D_BLD: acc_ff <= SUM_W'(bias_rd_ff);
         ST_D_ACC: acc_ff <= sat_add(acc_ff, term_ext);
         ST_DIV: begin
            if (sq_rsp.done && final_layer &&
                (r_ff == '0 || sq_rsp.act > bestv_ff)) begin
               best_ff  <= r_ff[ROW_W-1:0];
               bestv_ff <= sq_rsp.act;
            end
         end
         ST_O_LD: begin
            rsp_data_ff <= {{(32-2*ROW_W-ACT_W){1'b0}}, best_ff, act_rd_ff,
                            r_ff[ROW_W-1:0]};
            rsp_last_ff <= r_next == out_size;
         end
         default: ;
      endcase
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/mfi_checker.sv */
module mfi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // no new request taken while results are still being delivered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted during result delivery");

   // activation never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:6] <= 13'd4096)
      else $error("activation above one");

   // the winning neuron is among those reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[24:19] <= rsp_tdata[5:0])
      else $error("best class out of range");

endmodule

bind mlp_feedforward_inference_unit mfi_checker u_mfi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
